FILE: rtl/core/fuqp_pkg.sv
`default_nettype none
package fuqp_pkg;

    typedef enum logic [2:0] {
        CLS_PLAIN  = 3'd0,
        CLS_PLUS   = 3'd1,
        CLS_PCT    = 3'd2,
        CLS_AMP    = 3'd3,
        CLS_EQ     = 3'd4,
        CLS_FORBID = 3'd5
    } char_class_t;

    typedef enum logic [1:0] {
        ST_CONT   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FC_NONE      = 3'd0,
        FC_FORBIDDEN = 3'd1,
        FC_BAD_HEX   = 3'd2,
        FC_NAME_LONG = 3'd3,
        FC_VAL_LONG  = 3'd4,
        FC_PAIRS     = 3'd5,
        FC_EARLY_END = 3'd6,
        FC_MISPLACED = 3'd7
    } fail_cause_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_step_t;

    typedef enum logic [1:0] {
        CFG_MAX_NAME_LEN  = 2'd0,
        CFG_MAX_VALUE_LEN = 2'd1,
        CFG_MAX_PAIRS     = 2'd2
    } cfg_index_t;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PCT     = 8'h25;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQ      = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [3:0] HEX_LETTER_0 = 4'hA;

    localparam logic [15:0] RST_MAX_NAME_LEN  = 16'd256;
    localparam logic [15:0] RST_MAX_VALUE_LEN = 16'd1024;
    localparam logic [9:0]  RST_MAX_PAIRS     = 10'd64;

    // One classified input word as it sits in the queue.
    typedef struct packed {
        logic [7:0]  ch;
        logic        at_end;
        char_class_t cls;
        logic        hex_ok;
        logic [3:0]  hex_val;
    } item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  decoded_byte;
        logic        in_value;
        logic        field_done;
        status_t     status;
        fail_cause_t fail_cause;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/fuqp_front.sv
`default_nettype none
module fuqp_front (
    input  wire logic [7:0]     char_in,
    input  wire logic           at_end,
    output fuqp_pkg::item_t     item
);

    always_comb
    begin
        item.ch      = char_in;
        item.at_end  = at_end;
        item.hex_ok  = 1'b1;
        item.hex_val = 4'd0;
        if (char_in inside {[8'h30:8'h39]})
        begin
            item.hex_val = char_in[3:0];
        end
        else if (char_in inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            item.hex_val = 4'(char_in[2:0] - 3'd1) + fuqp_pkg::HEX_LETTER_0;
        end
        else
        begin
            item.hex_ok = 1'b0;
        end

        case (char_in)
            fuqp_pkg::CHAR_PLUS: item.cls = fuqp_pkg::CLS_PLUS;
            fuqp_pkg::CHAR_PCT:  item.cls = fuqp_pkg::CLS_PCT;
            fuqp_pkg::CHAR_AMP:  item.cls = fuqp_pkg::CLS_AMP;
            fuqp_pkg::CHAR_EQ:   item.cls = fuqp_pkg::CLS_EQ;
            default:
            begin
                if (char_in <= fuqp_pkg::CHAR_SPACE || char_in[7])
                begin
                    item.cls = fuqp_pkg::CLS_FORBID;
                end
                else
                begin
                    item.cls = fuqp_pkg::CLS_PLAIN;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/fuqp_fifo.sv
`default_nettype none
module fuqp_fifo #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  not_empty,
    output logic                  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/fuqp_back.sv
`default_nettype none
module fuqp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              q_valid,
    input  wire fuqp_pkg::item_t   q_item,
    output logic                   q_pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output fuqp_pkg::result_t      out_res
);

    logic [15:0] max_name_len_reg;
    logic [15:0] max_value_len_reg;
    logic [9:0]  max_pairs_reg;

    logic                phase_reg, phase_next;
    fuqp_pkg::esc_step_t esc_reg, esc_next;
    logic [3:0]          nib_reg, nib_next;
    logic [15:0]         name_cnt_reg, name_cnt_next;
    logic [15:0]         val_cnt_reg, val_cnt_next;
    logic [9:0]          pairs_left_reg, pairs_left_next;
    logic                failed_reg, failed_next;

    logic                out_valid_reg;
    fuqp_pkg::result_t   res_reg, res_next;

    logic                dlv;
    logic [7:0]          dlv_byte;
    logic                fail;
    fuqp_pkg::fail_cause_t fail_cause;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        nib_next        = nib_reg;
        name_cnt_next   = name_cnt_reg;
        val_cnt_next    = val_cnt_reg;
        pairs_left_next = pairs_left_reg;
        failed_next     = failed_reg;
        dlv             = 1'b0;
        dlv_byte        = q_item.ch;
        fail            = 1'b0;
        fail_cause      = fuqp_pkg::FC_NONE;

        res_next.byte_valid   = 1'b0;
        res_next.decoded_byte = 8'd0;
        res_next.in_value     = phase_reg;
        res_next.field_done   = 1'b0;
        res_next.status       = fuqp_pkg::ST_CONT;
        res_next.fail_cause   = fuqp_pkg::FC_NONE;

        if (q_item.at_end)
        begin
            res_next.status = fuqp_pkg::ST_REJECT;
            if (failed_reg)
            begin
                res_next.fail_cause = fuqp_pkg::FC_NONE;
            end
            else if (esc_reg != fuqp_pkg::ESC_NONE)
            begin
                res_next.fail_cause = fuqp_pkg::FC_EARLY_END;
            end
            else if (!phase_reg)
            begin
                if (name_cnt_reg != '0)
                begin
                    res_next.fail_cause = fuqp_pkg::FC_EARLY_END;
                end
                else
                begin
                    res_next.status = fuqp_pkg::ST_ACCEPT;
                end
            end
            else if (pairs_left_reg == '0)
            begin
                res_next.fail_cause = fuqp_pkg::FC_PAIRS;
            end
            else
            begin
                res_next.status     = fuqp_pkg::ST_ACCEPT;
                res_next.field_done = 1'b1;
            end
            phase_next      = 1'b0;
            esc_next        = fuqp_pkg::ESC_NONE;
            nib_next        = 4'd0;
            name_cnt_next   = '0;
            val_cnt_next    = '0;
            pairs_left_next = max_pairs_reg;
            failed_next     = 1'b0;
        end
        else if (failed_reg)
        begin
            res_next.status = fuqp_pkg::ST_REJECT;
        end
        else if (esc_reg == fuqp_pkg::ESC_HIGH)
        begin
            if (!q_item.hex_ok)
            begin
                fail       = 1'b1;
                fail_cause = fuqp_pkg::FC_BAD_HEX;
            end
            else
            begin
                nib_next = q_item.hex_val;
                esc_next = fuqp_pkg::ESC_LOW;
            end
        end
        else if (esc_reg == fuqp_pkg::ESC_LOW)
        begin
            if (!q_item.hex_ok)
            begin
                fail       = 1'b1;
                fail_cause = fuqp_pkg::FC_BAD_HEX;
            end
            else
            begin
                esc_next = fuqp_pkg::ESC_NONE;
                dlv      = 1'b1;
                dlv_byte = {nib_reg, q_item.hex_val};
            end
        end
        else
        begin
            case (q_item.cls)
                fuqp_pkg::CLS_PLUS:
                begin
                    dlv      = 1'b1;
                    dlv_byte = fuqp_pkg::CHAR_SPACE;
                end
                fuqp_pkg::CLS_PCT:
                begin
                    esc_next = fuqp_pkg::ESC_HIGH;
                end
                fuqp_pkg::CLS_AMP:
                begin
                    if (!phase_reg)
                    begin
                        fail       = 1'b1;
                        fail_cause = fuqp_pkg::FC_MISPLACED;
                    end
                    else if (pairs_left_reg == '0)
                    begin
                        fail       = 1'b1;
                        fail_cause = fuqp_pkg::FC_PAIRS;
                    end
                    else
                    begin
                        pairs_left_next     = pairs_left_reg - 1'b1;
                        phase_next          = 1'b0;
                        name_cnt_next       = '0;
                        res_next.field_done = 1'b1;
                    end
                end
                fuqp_pkg::CLS_EQ:
                begin
                    if (phase_reg)
                    begin
                        fail       = 1'b1;
                        fail_cause = fuqp_pkg::FC_MISPLACED;
                    end
                    else
                    begin
                        phase_next          = 1'b1;
                        val_cnt_next        = '0;
                        res_next.field_done = 1'b1;
                    end
                end
                fuqp_pkg::CLS_FORBID:
                begin
                    fail       = 1'b1;
                    fail_cause = fuqp_pkg::FC_FORBIDDEN;
                end
                default:
                begin
                    dlv = 1'b1;
                end
            endcase
        end

        if (dlv)
        begin
            if (!phase_reg)
            begin
                if (name_cnt_reg >= max_name_len_reg)
                begin
                    fail       = 1'b1;
                    fail_cause = fuqp_pkg::FC_NAME_LONG;
                end
                else
                begin
                    name_cnt_next = name_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (val_cnt_reg >= max_value_len_reg)
                begin
                    fail       = 1'b1;
                    fail_cause = fuqp_pkg::FC_VAL_LONG;
                end
                else
                begin
                    val_cnt_next = val_cnt_reg + 1'b1;
                end
            end
            if (!fail)
            begin
                res_next.byte_valid   = 1'b1;
                res_next.decoded_byte = dlv_byte;
            end
        end

        if (fail)
        begin
            failed_next         = 1'b1;
            res_next.status     = fuqp_pkg::ST_REJECT;
            res_next.fail_cause = fail_cause;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_len_reg  <= fuqp_pkg::RST_MAX_NAME_LEN;
            max_value_len_reg <= fuqp_pkg::RST_MAX_VALUE_LEN;
            max_pairs_reg     <= fuqp_pkg::RST_MAX_PAIRS;
            phase_reg         <= 1'b0;
            esc_reg           <= fuqp_pkg::ESC_NONE;
            nib_reg           <= 4'd0;
            name_cnt_reg      <= '0;
            val_cnt_reg       <= '0;
            pairs_left_reg    <= fuqp_pkg::RST_MAX_PAIRS;
            failed_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg      <= phase_next;
                esc_reg        <= esc_next;
                nib_reg        <= nib_next;
                name_cnt_reg   <= name_cnt_next;
                val_cnt_reg    <= val_cnt_next;
                pairs_left_reg <= pairs_left_next;
                failed_reg     <= failed_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fuqp_pkg::CFG_MAX_NAME_LEN:  max_name_len_reg  <= cfg_data;
                    fuqp_pkg::CFG_MAX_VALUE_LEN: max_value_len_reg <= cfg_data;
                    fuqp_pkg::CFG_MAX_PAIRS:
                    begin
                        max_pairs_reg  <= cfg_data[9:0];
                        pairs_left_reg <= cfg_data[9:0];
                    end
                    default:
                    begin
                        max_pairs_reg <= max_pairs_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/form_urlencoded_query_parser.sv
// Form-urlencoded query string parser.
// Input words arrive on the s_ stream: s_tdata carries one raw query byte and
// s_tlast marks the end of the string (the byte is then ignored). Every input
// word yields exactly one output word on the m_ stream, in order.
// Each output word carries an optional decoded byte, the name/value phase on
// m_tuser, a field-closed flag on m_tlast, and a status with a failure cause.
// Limits are set through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block idles, which the block does not enforce. A front
// stage classifies each byte into a queue of QUEUE_DEPTH words, and a back
// stage updates the parser state and loads the output register. Throughput is
// one word per cycle while the receiver keeps m_tready high.
// When the receiver holds m_tready low, the output register and the queue
// absorb up to QUEUE_DEPTH + 1 words before s_tready drops.
// Reset empties the queue and output register, restores the default limits
// and returns the parser to the start of a name. An end marker rearms it.
`default_nettype none
module form_urlencoded_query_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [0] byte_valid, [8:1] decoded_byte,
                                        // [10:9] status, [13:11] fail_cause
    output logic             m_tuser,   // [0] in_value
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int ITEM_W = $bits(fuqp_pkg::item_t);

    fuqp_pkg::item_t   in_item;
    fuqp_pkg::item_t   q_item;
    logic [ITEM_W-1:0] q_data;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;
    logic              push;
    fuqp_pkg::result_t res;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign q_item   = fuqp_pkg::item_t'(q_data);

    fuqp_front u_front (
        .char_in (s_tdata),
        .at_end  (s_tlast),
        .item    (in_item)
    );

    fuqp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (in_item),
        .pop       (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid),
        .full      (q_full)
    );

    fuqp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.fail_cause, res.status, res.decoded_byte, res.byte_valid};
    assign m_tuser = res.in_value;
    assign m_tlast = res.field_done;

    a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status == fuqp_pkg::ST_REJECT |-> !res.byte_valid && !res.field_done)
        else $error("rejected word carries data or closes a field");

    a_byte_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.byte_valid |-> res.status == fuqp_pkg::ST_CONT && !res.field_done)
        else $error("decoded byte delivered with a final status");

    a_value_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status == fuqp_pkg::ST_ACCEPT && res.in_value |-> res.field_done)
        else $error("accepted string in value phase did not close the value");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !q_pop)
        else $error("back stage overwrote a stalled result");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_FREE,
        ROW_CHECK,
        ROW_LIMITS
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [7:0]         ch;
        logic               last;
        fuqp_pkg::result_t  exp;
    } query_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] char_in
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [0] byte_valid, [8:1] decoded_byte,
                                     // [10:9] status, [13:11] fail_cause
    logic        m_tuser;            // [0] in_value
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'h0000;

    // Limits and parser state as the block should hold them.
    logic [15:0]         lim_name = fuqp_pkg::RST_MAX_NAME_LEN;
    logic [15:0]         lim_value = fuqp_pkg::RST_MAX_VALUE_LEN;
    logic [9:0]          lim_pairs = fuqp_pkg::RST_MAX_PAIRS;
    logic                q_in_value = 1'b0;
    fuqp_pkg::esc_step_t q_esc = fuqp_pkg::ESC_NONE;
    logic [3:0]          q_high = 4'h0;
    logic [15:0]         q_name_len = 16'd0;
    logic [15:0]         q_value_len = 16'd0;
    logic [9:0]          q_pairs_left = fuqp_pkg::RST_MAX_PAIRS;
    logic                q_failed = 1'b0;

    fuqp_pkg::result_t expected_words[$];
    query_row_t        query_rows[$];
    int                mismatches = 0;
    int                phase_words = 0;
    bit                calm = 1'b0;

    form_urlencoded_query_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b1, c[3:0] - 4'd1 + fuqp_pkg::HEX_LETTER_0};
        end
        return 5'd0;
    endfunction

    function automatic fuqp_pkg::result_t reject_with(input logic phase,
                                                      input fuqp_pkg::fail_cause_t cause);
        q_failed = 1'b1;
        return {1'b0, 8'h00, phase, 1'b0, fuqp_pkg::ST_REJECT, cause};
    endfunction

    function automatic fuqp_pkg::result_t emit_byte(input logic phase, input logic [7:0] b);
        if (!phase)
        begin
            if (q_name_len >= lim_name)
            begin
                return reject_with(phase, fuqp_pkg::FC_NAME_LONG);
            end
            q_name_len = q_name_len + 16'd1;
        end
        else
        begin
            if (q_value_len >= lim_value)
            begin
                return reject_with(phase, fuqp_pkg::FC_VAL_LONG);
            end
            q_value_len = q_value_len + 16'd1;
        end
        return {1'b1, b, phase, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE};
    endfunction

    function automatic fuqp_pkg::result_t decode_step(input logic [7:0] c, input logic last);
        fuqp_pkg::result_t r;
        logic [4:0]        h;
        logic              phase;
        phase = q_in_value;
        h = hex_nibble(c);
        r = {1'b0, 8'h00, phase, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE};
        if (last)
        begin
            if (q_failed)
            begin
                r.status = fuqp_pkg::ST_REJECT;
            end
            else if (q_esc != fuqp_pkg::ESC_NONE || (!phase && q_name_len != 16'd0))
            begin
                r.status = fuqp_pkg::ST_REJECT;
                r.fail_cause = fuqp_pkg::FC_EARLY_END;
            end
            else if (!phase)
            begin
                r.status = fuqp_pkg::ST_ACCEPT;
            end
            else if (q_pairs_left == 10'd0)
            begin
                r.status = fuqp_pkg::ST_REJECT;
                r.fail_cause = fuqp_pkg::FC_PAIRS;
            end
            else
            begin
                r.field_done = 1'b1;
                r.status = fuqp_pkg::ST_ACCEPT;
            end
            q_in_value = 1'b0;
            q_esc = fuqp_pkg::ESC_NONE;
            q_high = 4'h0;
            q_name_len = 16'd0;
            q_value_len = 16'd0;
            q_pairs_left = lim_pairs;
            q_failed = 1'b0;
        end
        else if (q_failed)
        begin
            r.status = fuqp_pkg::ST_REJECT;
        end
        else if (q_esc == fuqp_pkg::ESC_HIGH)
        begin
            if (!h[4])
            begin
                r = reject_with(phase, fuqp_pkg::FC_BAD_HEX);
            end
            else
            begin
                q_high = h[3:0];
                q_esc = fuqp_pkg::ESC_LOW;
            end
        end
        else if (q_esc == fuqp_pkg::ESC_LOW)
        begin
            if (!h[4])
            begin
                r = reject_with(phase, fuqp_pkg::FC_BAD_HEX);
            end
            else
            begin
                q_esc = fuqp_pkg::ESC_NONE;
                r = emit_byte(phase, {q_high, h[3:0]});
            end
        end
        else if (c == fuqp_pkg::CHAR_PLUS)
        begin
            r = emit_byte(phase, fuqp_pkg::CHAR_SPACE);
        end
        else if (c == fuqp_pkg::CHAR_PCT)
        begin
            q_esc = fuqp_pkg::ESC_HIGH;
        end
        else if ((!phase && c == fuqp_pkg::CHAR_AMP) || (phase && c == fuqp_pkg::CHAR_EQ))
        begin
            r = reject_with(phase, fuqp_pkg::FC_MISPLACED);
        end
        else if (!phase && c == fuqp_pkg::CHAR_EQ)
        begin
            q_in_value = 1'b1;
            q_value_len = 16'd0;
            r.field_done = 1'b1;
        end
        else if (phase && c == fuqp_pkg::CHAR_AMP)
        begin
            if (q_pairs_left == 10'd0)
            begin
                r = reject_with(phase, fuqp_pkg::FC_PAIRS);
            end
            else
            begin
                q_pairs_left = q_pairs_left - 10'd1;
                q_in_value = 1'b0;
                q_name_len = 16'd0;
                r.field_done = 1'b1;
            end
        end
        else if (c <= fuqp_pkg::CHAR_SPACE || c[7])
        begin
            r = reject_with(phase, fuqp_pkg::FC_FORBIDDEN);
        end
        else
        begin
            r = emit_byte(phase, c);
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input bit noisy);
        logic [3:0] v;
        if (noisy && $urandom_range(0, 7) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        v = 4'($urandom_range(0, 15));
        if (v < fuqp_pkg::HEX_LETTER_0)
        begin
            return 8'h30 + v;
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - fuqp_pkg::HEX_LETTER_0);
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic last);
        while (!calm && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_words.push_back(decode_step(ch, last));
        phase_words++;
    endtask

    task automatic await_drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [15:0] n, input logic [15:0] v,
                              input logic [9:0] p, input bit poke_unused);
        cfg_we <= 1'b1;
        cfg_index <= fuqp_pkg::CFG_MAX_NAME_LEN;
        cfg_data <= n;
        @(posedge clk);
        lim_name = n;
        cfg_index <= fuqp_pkg::CFG_MAX_VALUE_LEN;
        cfg_data <= v;
        @(posedge clk);
        lim_value = v;
        cfg_index <= fuqp_pkg::CFG_MAX_PAIRS;
        cfg_data <= {6'd0, p};
        @(posedge clk);
        lim_pairs = p;
        q_pairs_left = p;
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data <= 16'hFFFF;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_field(input int len, input bit noisy);
        int         pick;
        logic [7:0] ch;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 11);
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick == 0)
            begin
                send_word(fuqp_pkg::CHAR_PLUS, 1'b0);
            end
            else if (pick <= 2)
            begin
                send_word(fuqp_pkg::CHAR_PCT, 1'b0);
                send_word(hex_char(noisy), 1'b0);
                send_word(hex_char(noisy), 1'b0);
            end
            else
            begin
                do
                    ch = 8'($urandom_range(8'h21, 8'h7E));
                while (ch == fuqp_pkg::CHAR_PLUS || ch == fuqp_pkg::CHAR_PCT
                       || ch == fuqp_pkg::CHAR_AMP || ch == fuqp_pkg::CHAR_EQ);
                send_word(ch, 1'b0);
            end
        end
    endtask

    // Mostly well-formed query strings sized around the current limits, so the
    // limit checks trip; a fifth of them carry noise or stop early.
    task automatic send_query();
        int pairs;
        int name_span;
        int value_span;
        int cut;
        bit noisy;
        noisy = ($urandom_range(0, 99) < 20);
        name_span = (lim_name <= 16'd6) ? int'(lim_name) + 1 : 6;
        value_span = (lim_value <= 16'd6) ? int'(lim_value) + 1 : 6;
        pairs = $urandom_range(0, (lim_pairs <= 10'd5) ? int'(lim_pairs) + 1 : 4);
        for (int i = 0; i < pairs; i++)
        begin
            if (i != 0)
            begin
                send_word(fuqp_pkg::CHAR_AMP, 1'b0);
            end
            send_field($urandom_range(0, name_span), noisy);
            cut = noisy ? $urandom_range(0, 7) : 7;
            if (cut == 0)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
                return;
            end
            if (cut == 1)
            begin
                send_word(fuqp_pkg::CHAR_PCT, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
                return;
            end
            send_word(fuqp_pkg::CHAR_EQ, 1'b0);
            send_field($urandom_range(0, value_span), noisy);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            send_word(fuqp_pkg::CHAR_AMP, 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_row(input row_kind_t kind, input logic [7:0] ch, input logic last,
                           input fuqp_pkg::result_t exp);
        query_row_t row;
        row.kind = kind;
        row.ch = ch;
        row.last = last;
        row.exp = exp;
        query_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin : check_results
        fuqp_pkg::result_t seen;
        fuqp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.byte_valid = m_tdata[0];
            seen.decoded_byte = m_tdata[8:1];
            seen.in_value = m_tuser;
            seen.field_done = m_tlast;
            seen.status = fuqp_pkg::status_t'(m_tdata[10:9]);
            seen.fail_cause = fuqp_pkg::fail_cause_t'(m_tdata[13:11]);
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected word at %0t: m_tdata=%h m_tuser=%b m_tlast=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                end
            end
            else
            begin
                want = expected_words.pop_front();
                if (seen.byte_valid !== want.byte_valid
                    || seen.decoded_byte !== want.decoded_byte
                    || seen.in_value !== want.in_value
                    || seen.field_done !== want.field_done
                    || seen.status !== want.status
                    || seen.fail_cause !== want.fail_cause)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: expected bv=%b byte=%h iv=%b done=%b st=%0d fc=%0d",
                                 $realtime, want.byte_valid, want.decoded_byte, want.in_value,
                                 want.field_done, want.status, want.fail_cause);
                        $display("                    actual bv=%b byte=%h iv=%b done=%b st=%0d fc=%0d",
                                 seen.byte_valid, seen.decoded_byte, seen.in_value,
                                 seen.field_done, seen.status, seen.fail_cause);
                    end
                end
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 13);
    end

    initial
    begin : stimulus
        logic [15:0] nl;
        logic [15:0] vl;
        logic [9:0]  pl;
        bit          held;
        held = 1'b0;

        // Reset limits; end markers carry arbitrary bytes, which must be ignored.
        add_row(ROW_CHECK, 8'hFF, 1'b1,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_ACCEPT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, 8'h61, 1'b0,
                {1'b1, 8'h61, 1'b0, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, fuqp_pkg::CHAR_PLUS, 1'b0,
                {1'b1, 8'h20, 1'b0, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_FREE, fuqp_pkg::CHAR_PCT, 1'b0, '0);
        add_row(ROW_FREE, 8'h66, 1'b0, '0);
        add_row(ROW_CHECK, 8'h46, 1'b0,
                {1'b1, 8'hFF, 1'b0, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, fuqp_pkg::CHAR_EQ, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b1, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, 8'h7E, 1'b0,
                {1'b1, 8'h7E, 1'b1, 1'b0, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, fuqp_pkg::CHAR_AMP, 1'b0,
                {1'b0, 8'h00, 1'b1, 1'b1, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, fuqp_pkg::CHAR_EQ, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b1, fuqp_pkg::ST_CONT, fuqp_pkg::FC_NONE});
        add_row(ROW_FREE, 8'h21, 1'b0, '0);
        add_row(ROW_CHECK, 8'h00, 1'b1,
                {1'b0, 8'h00, 1'b1, 1'b1, fuqp_pkg::ST_ACCEPT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, 8'h20, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_FORBIDDEN});
        add_row(ROW_CHECK, 8'h78, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_NONE});
        add_row(ROW_CHECK, 8'h00, 1'b1,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_NONE});
        add_row(ROW_FREE, fuqp_pkg::CHAR_PCT, 1'b0, '0);
        add_row(ROW_FREE, 8'h34, 1'b0, '0);
        add_row(ROW_CHECK, 8'h67, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_BAD_HEX});
        add_row(ROW_FREE, 8'h00, 1'b1, '0);
        add_row(ROW_CHECK, fuqp_pkg::CHAR_AMP, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_MISPLACED});
        add_row(ROW_FREE, 8'h00, 1'b1, '0);
        add_row(ROW_FREE, 8'h61, 1'b0, '0);
        add_row(ROW_CHECK, 8'h00, 1'b1,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_EARLY_END});
        add_row(ROW_FREE, fuqp_pkg::CHAR_PCT, 1'b0, '0);
        add_row(ROW_CHECK, 8'h00, 1'b1,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_EARLY_END});
        // All limits at one.
        add_row(ROW_LIMITS, 8'h00, 1'b0, '0);
        add_row(ROW_FREE, 8'h61, 1'b0, '0);
        add_row(ROW_CHECK, 8'h62, 1'b0,
                {1'b0, 8'h00, 1'b0, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_NAME_LONG});
        add_row(ROW_FREE, 8'h00, 1'b1, '0);
        add_row(ROW_FREE, fuqp_pkg::CHAR_EQ, 1'b0, '0);
        add_row(ROW_FREE, 8'h78, 1'b0, '0);
        add_row(ROW_CHECK, 8'h79, 1'b0,
                {1'b0, 8'h00, 1'b1, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_VAL_LONG});
        add_row(ROW_FREE, 8'h00, 1'b1, '0);
        add_row(ROW_FREE, fuqp_pkg::CHAR_EQ, 1'b0, '0);
        add_row(ROW_FREE, fuqp_pkg::CHAR_AMP, 1'b0, '0);
        add_row(ROW_FREE, fuqp_pkg::CHAR_EQ, 1'b0, '0);
        add_row(ROW_CHECK, 8'h00, 1'b1,
                {1'b0, 8'h00, 1'b1, 1'b0, fuqp_pkg::ST_REJECT, fuqp_pkg::FC_PAIRS});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (query_rows[r])
        begin
            if (query_rows[r].kind == ROW_LIMITS)
            begin
                await_drain();
                set_limits(16'd1, 16'd1, 10'd1, 1'b0);
            end
            else
            begin
                send_word(query_rows[r].ch, query_rows[r].last);
                if (query_rows[r].kind == ROW_CHECK)
                begin
                    expected_words[expected_words.size() - 1] = query_rows[r].exp;
                end
            end
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:
                begin
                    nl = 16'hFFFF;
                    vl = 16'hFFFF;
                    pl = 10'h3FF;
                end
                1:
                begin
                    nl = 16'd1;
                    vl = 16'd1;
                    pl = 10'd1;
                end
                2:
                begin
                    nl = fuqp_pkg::RST_MAX_NAME_LEN;
                    vl = fuqp_pkg::RST_MAX_VALUE_LEN;
                    pl = fuqp_pkg::RST_MAX_PAIRS;
                end
                default:
                begin
                    nl = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 65535))
                                                     : 16'($urandom_range(1, 6));
                    vl = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 65535))
                                                     : 16'($urandom_range(1, 6));
                    pl = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(6, 1023))
                                                     : 10'($urandom_range(1, 5));
                end
            endcase
            await_drain();
            set_limits(nl, vl, pl, ph == 2);
            calm = (ph == 0);
            phase_words = 0;
            while (phase_words < 100)
            begin
                send_query();
                if (ph == 5 && !held && phase_words >= 50)
                begin
                    await_drain();
                    held = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        for (int k = 0; k < 20000 && expected_words.size() != 0; k++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        mismatches += expected_words.size();
        if (mismatches == 0)
        begin
            $display("[form_urlencoded_query_parser] OK");
        end
        else
        begin
            $display("[form_urlencoded_query_parser] ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("[form_urlencoded_query_parser] ERROR");
        $finish;
    end

endmodule
